>>> hdl/tuv_pkg.sv
// ----------------------------------------------------------------------------
// tuv_pkg
// Shared types and constants for the torus UV texture map unit.
// ----------------------------------------------------------------------------
package tuv_pkg;

  localparam int RingW       = 23;
  localparam int TexW        = 17;
  localparam int NormW       = 53;
  localparam int NormStages  = 6;
  localparam int CordicSteps = 30;
  localparam int CxW         = 56;
  localparam int AngW        = 34;
  localparam int AddrW       = 3;

  localparam logic [RingW-1:0] RingReset = 23'd65536;
  localparam logic [AddrW-1:0] RegRingRadius = 3'd0;

  localparam logic [31:0] AtanTurns [CordicSteps] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  typedef struct packed {
    logic zero;
    logic swap;
    logic bneg;
    logic aneg;
  } tuv_flags_t;

endpackage

>>> hdl/tuv_in_if.sv
// ----------------------------------------------------------------------------
// tuv_in_if
// Point channel: signed surface coordinates.
// ----------------------------------------------------------------------------
interface tuv_in_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;

  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

>>> hdl/tuv_out_if.sv
// ----------------------------------------------------------------------------
// tuv_out_if
// Texture coordinate channel: Q1.16 turns.
// ----------------------------------------------------------------------------
interface tuv_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] tex_u;
  logic [16:0] tex_v;

  modport source (output valid, tex_u, tex_v, input ready);
  modport sink (input valid, tex_u, tex_v, output ready);
endinterface

>>> hdl/tuv_sqrt.sv
// ----------------------------------------------------------------------------
// tuv_sqrt
// Pipelined integer square root, one result bit per stage, with side payload.
// ----------------------------------------------------------------------------
module tuv_sqrt #(
  parameter int ROOT_W = 24,
  parameter int PAY_W  = 72
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [2*ROOT_W-1:0]   rad_i,
  input  logic [PAY_W-1:0]      pay_i,
  output logic                  valid_o,
  output logic [ROOT_W-1:0]     root_o,
  output logic [PAY_W-1:0]      pay_o
);
  localparam int SqW  = 2 * ROOT_W;
  localparam int RemW = ROOT_W + 2;

  logic              vld_q  [0:ROOT_W];
  logic [SqW-1:0]    rad_q  [0:ROOT_W];
  logic [RemW-1:0]   rem_q  [0:ROOT_W];
  logic [ROOT_W-1:0] root_q [0:ROOT_W];
  logic [PAY_W-1:0]  pay_q  [0:ROOT_W];

  assign vld_q[0]  = valid_i;
  assign rad_q[0]  = rad_i;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign pay_q[0]  = pay_i;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [RemW-1:0] rem2, trial;
    logic            fit;
    assign rem2  = {rem_q[k][ROOT_W-1:0], rad_q[k][SqW-1 -: 2]};
    assign trial = {root_q[k], 2'b01};
    assign fit   = rem2 >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k+1]  <= {rad_q[k][SqW-3:0], 2'b00};
        rem_q[k+1]  <= fit ? rem2 - trial : rem2;
        root_q[k+1] <= {root_q[k][ROOT_W-2:0], fit};
        pay_q[k+1]  <= pay_q[k];
      end
    end
  end

  assign valid_o = vld_q[ROOT_W];
  assign root_o  = root_q[ROOT_W];
  assign pay_o   = pay_q[ROOT_W];
endmodule

>>> hdl/tuv_atan.sv
// ----------------------------------------------------------------------------
// tuv_atan
// Pipelined atan2 to Q1.16 turn: octant fold, normalize, CORDIC, unfold.
// ----------------------------------------------------------------------------
module tuv_atan #(
  parameter int IN_W = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [IN_W-1:0] a_i,
  input  logic signed [IN_W-1:0] b_i,
  output logic                   valid_o,
  output logic [tuv_pkg::TexW-1:0] turn_o
);
  import tuv_pkg::*;

  localparam int CyEnd = NormStages + CordicSteps;

  logic [IN_W-1:0]  am, bm;
  tuv_flags_t       fl_in;

  logic               vld_q [0:CyEnd];
  tuv_flags_t         fl_q  [0:CyEnd];
  logic [NormW-1:0]   hi_q  [0:NormStages];
  logic [NormW-1:0]   lo_q  [0:NormStages];
  logic signed [CxW-1:0]  cx_q [0:CordicSteps];
  logic signed [CxW-1:0]  cy_q [0:CordicSteps];
  logic signed [AngW-1:0] z_q  [0:CordicSteps];

  logic                   out_vld_q;
  logic [TexW-1:0]        turn_q;
  logic signed [AngW-1:0] zc, ang1, ang2, ang3, res;

  assign am = a_i[IN_W-1] ? IN_W'(-a_i) : a_i;
  assign bm = b_i[IN_W-1] ? IN_W'(-b_i) : b_i;
  assign fl_in.zero = (am == '0) && (bm == '0);
  assign fl_in.swap = am > bm;
  assign fl_in.bneg = b_i[IN_W-1];
  assign fl_in.aneg = a_i[IN_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fl_q[0] <= fl_in;
      hi_q[0] <= NormW'(fl_in.swap ? am : bm);
      lo_q[0] <= NormW'(fl_in.swap ? bm : am);
    end
  end

  for (genvar j = 0; j < NormStages; j++) begin : g_norm
    localparam int S = 32 >> j;
    logic sh;
    assign sh = hi_q[j][NormW-1 -: S] == '0;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        fl_q[j+1] <= fl_q[j];
        hi_q[j+1] <= sh ? (hi_q[j] << S) : hi_q[j];
        lo_q[j+1] <= sh ? (lo_q[j] << S) : lo_q[j];
      end
    end
  end

  assign cx_q[0] = signed'(CxW'(hi_q[NormStages]));
  assign cy_q[0] = signed'(CxW'(lo_q[NormStages]));
  assign z_q[0]  = '0;

  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    logic signed [CxW-1:0]  xs, ys;
    logic signed [AngW-1:0] at;
    assign xs = cx_q[i] >>> i;
    assign ys = cy_q[i] >>> i;
    assign at = signed'(AngW'(AtanTurns[i]));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[NormStages+i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[NormStages+i+1] <= vld_q[NormStages+i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        fl_q[NormStages+i+1] <= fl_q[NormStages+i];
        if (cy_q[i] > 0) begin
          cx_q[i+1] <= cx_q[i] + ys;
          cy_q[i+1] <= cy_q[i] - xs;
          z_q[i+1]  <= z_q[i] + at;
        end else if (cy_q[i] < 0) begin
          cx_q[i+1] <= cx_q[i] - ys;
          cy_q[i+1] <= cy_q[i] + xs;
          z_q[i+1]  <= z_q[i] - at;
        end else begin
          cx_q[i+1] <= cx_q[i];
          cy_q[i+1] <= cy_q[i];
          z_q[i+1]  <= z_q[i];
        end
      end
    end
  end

  always_comb begin
    zc = z_q[CordicSteps];
    if (zc < 0) begin
      zc = '0;
    end
    if (zc > (AngW'(1) <<< 29)) begin
      zc = AngW'(1) <<< 29;
    end
    ang1 = fl_q[CyEnd].swap ? (AngW'(1) <<< 30) - zc : zc;
    ang2 = fl_q[CyEnd].bneg ? (AngW'(1) <<< 31) - ang1 : ang1;
    ang3 = fl_q[CyEnd].aneg ? -ang2 : ang2;
    res  = ang3 + (AngW'(1) <<< 31) + (AngW'(1) <<< 15);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[CyEnd];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      turn_q <= fl_q[CyEnd].zero ? TexW'(32768) : res[32:16];
    end
  end

  assign valid_o = out_vld_q;
  assign turn_o  = turn_q;

`ifndef SYNTHESIS
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> turn_o <= TexW'(65536)) else $error("turn out of range");
  a_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NormStages] && !fl_q[NormStages].zero |-> hi_q[NormStages][NormW-1])
    else $error("normalize failed");
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NormStages] |-> lo_q[NormStages] <= hi_q[NormStages])
    else $error("octant fold failed");
`endif
endmodule

>>> hdl/torus_uv_texture_map_unit.sv
// Throughput: one point per cycle; the whole pipeline holds while the result is stalled.
// Built from the one-bit-per-stage square root and the 30-stage CORDIC units.
// Reset: asynchronous, active low; clears valid bits, the ring register returns to 1.0.
// ----------------------------------------------------------------------------
// torus_uv_texture_map_unit
// Surface point to torus UV turns: squares, square root, two atan2 pipelines.
// ----------------------------------------------------------------------------
module torus_uv_texture_map_unit #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tuv_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  tuv_in_if.sink                     in_i,
  tuv_out_if.source                  out_o
);
  import tuv_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int DW  = ((CB > RingW) ? CB : RingW) + 1;
  localparam int PW  = 3 * CB;
  localparam int FbW = (FRAC_BITS < CB) ? FRAC_BITS : CB;

  logic en;
  logic [RingW-1:0] ring_q;

  logic                 v0_q, v1_q, v2_q, v3_q;
  logic signed [CB-1:0] x0_q, y0_q, z0_q, x1_q, y1_q, z1_q, x2_q, y2_q, z2_q;
  logic signed [CB-1:0] x3_q, y3_q, z3_q;
  logic [CB-1:0]        xm, ym;
  logic [2*CB-1:0]      sqx_q, sqy_q, sum_q;
  logic signed [DW-1:0] drz_q;

  logic                 sq_vld;
  logic [CB-1:0]        root;
  logic [PW-1:0]        sq_pay;
  logic                 u_vld, v_vld;
  logic [TexW-1:0]      u_turn, v_turn;

  // config
  assign pready = 1'b1;
  assign prdata = (paddr[AddrW-1] == RegRingRadius[AddrW-1]) ? 32'(ring_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q <= RingReset;
    end else if (psel && penable && pwrite && paddr[AddrW-1] == RegRingRadius[AddrW-1]) begin
      ring_q <= pwdata[RingW-1:0];
    end
  end

  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  assign xm = x0_q[CB-1] ? CB'(-x0_q) : x0_q;
  assign ym = y0_q[CB-1] ? CB'(-y0_q) : y0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_i.valid;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q  <= in_i.pos_x;
      y0_q  <= in_i.pos_y;
      z0_q  <= in_i.pos_z;
      sqx_q <= (2*CB)'(xm) * (2*CB)'(xm);
      sqy_q <= (2*CB)'(ym) * (2*CB)'(ym);
      {x1_q, y1_q, z1_q} <= {x0_q, y0_q, z0_q};
      sum_q <= sqx_q + sqy_q;
      {x2_q, y2_q, z2_q} <= {x1_q, y1_q, z1_q};
      drz_q <= signed'(DW'(root)) - signed'(DW'(ring_q));
      {x3_q, y3_q, z3_q} <= sq_pay;
    end
  end

  tuv_sqrt #(
    .ROOT_W (CB),
    .PAY_W  (PW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .rad_i   (sum_q),
    .pay_i   ({x2_q, y2_q, z2_q}),
    .valid_o (sq_vld),
    .root_o  (root),
    .pay_o   (sq_pay)
  );

  tuv_atan #(
    .IN_W (CB)
  ) u_atan_u (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .a_i     (y3_q),
    .b_i     (x3_q),
    .valid_o (u_vld),
    .turn_o  (u_turn)
  );

  tuv_atan #(
    .IN_W (DW)
  ) u_atan_v (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .a_i     (DW'(z3_q)),
    .b_i     (drz_q),
    .valid_o (v_vld),
    .turn_o  (v_turn)
  );

  assign out_o.valid = u_vld && v_vld;
  assign out_o.tex_u = u_turn;
  assign out_o.tex_v = v_turn;

`ifndef SYNTHESIS
  a_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_vld == v_vld) else $error("angle pipelines out of step");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready) else $error("spurious stall");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(sum_q) && $stable(drz_q)) else $error("pipeline moved in stall");
  a_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FbW <= CB) else $error("binary point beyond coordinate width");
`endif
endmodule

>>> bench/torus_uv_texture_map_unit_test.sv
// ----------------------------------------------------------------------------
// torus_uv_texture_map_unit_test
// Drives surface points through the torus UV unit under random idling on both
// channels, predicts each (tex_u, tex_v) pair with a behavioral CORDIC atan2,
// and checks results in order. Ring radius is reprogrammed between phases.
// ----------------------------------------------------------------------------
module torus_uv_texture_map_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tuv_pkg::*;

  localparam int CoordW   = 24;
  localparam int Latency  = CoordW + 41;
  localparam int NumRand  = 1550;
  localparam int NumPhase = 5;
  localparam logic [16:0] TexHalf = 17'd32768;
  localparam logic [16:0] TexFull = 17'd65536;
  localparam logic [16:0] TexNone = 17'h1ffff;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [16:0]              u;  // TexNone: predictor only
    logic [16:0]              v;
  } point_row_t;

  typedef struct packed {
    logic [16:0] u;
    logic [16:0] v;
  } tex_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tuv_in_if #(.COORD_BITS(CoordW)) pt_if ();
  tuv_out_if tex_if ();

  torus_uv_texture_map_unit #(.COORD_BITS(CoordW), .FRAC_BITS(16)) dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_i(pt_if.sink), .out_o(tex_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("torus_uv_texture_map_unit_test failed");
    $finish;
  end

  logic [RingW-1:0] ring_dist_q = RingReset;
  tex_t tex_expected[$];
  int unsigned mismatch_count = 0;
  bit calm = 1'b0;

  function automatic logic [63:0] mag64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] root, bit_q;
    root = 0;
    bit_q = 64'd1 << 62;
    while (bit_q > n) bit_q >>= 2;
    while (bit_q != 0) begin
      if (n >= root + bit_q) begin
        n -= root + bit_q;
        root = (root >> 1) + bit_q;
      end else begin
        root >>= 1;
      end
      bit_q >>= 2;
    end
    return root;
  endfunction

  // (atan2(a_s, b_s) + pi) / tau in Q1.16
  function automatic logic [16:0] turn_q16(longint a_s, longint b_s);
    logic [63:0] am, bm, hi, lo;
    longint cx, cy, ox, acc, ang;
    am = mag64(a_s);
    bm = mag64(b_s);
    acc = 0;
    if (am == 0 && bm == 0) return TexHalf;
    hi = am > bm ? am : bm;
    lo = am > bm ? bm : am;
    while (hi < (64'd1 << 52)) begin
      hi <<= 1;
      lo <<= 1;
    end
    cx = longint'(hi);
    cy = longint'(lo);
    for (int i = 0; i < CordicSteps; i++) begin
      ox = cx;
      if (cy > 0) begin
        cx += cy >>> i;
        cy -= ox >>> i;
        acc += longint'(AtanTurns[i]);
      end else if (cy < 0) begin
        cx -= cy >>> i;
        cy += ox >>> i;
        acc -= longint'(AtanTurns[i]);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 <<< 29)) acc = 64'sd1 <<< 29;
    ang = acc;
    if (am > bm) ang = (64'sd1 <<< 30) - ang;
    if (b_s < 0) ang = (64'sd1 <<< 31) - ang;
    if (a_s < 0) ang = -ang;
    return 17'((ang + (64'sd1 <<< 31) + (64'sd1 <<< 15)) >>> 16);
  endfunction

  function automatic tex_t torus_uv(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
                                    logic signed [CoordW-1:0] z);
    tex_t t;
    logic [63:0] xm, ym, rxy;
    xm = mag64(longint'(x));
    ym = mag64(longint'(y));
    rxy = isqrt(xm * xm + ym * ym);
    t.u = turn_q16(longint'(y), longint'(x));
    t.v = turn_q16(longint'(z), longint'(rxy) - longint'(ring_dist_q));
    return t;
  endfunction

  task automatic report(string what, logic [16:0] got, logic [16:0] want);
    mismatch_count++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  task automatic reg_write(logic [AddrW-1:0] addr, logic [31:0] data);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    ring_dist_q = data[RingW-1:0];
  endtask

  task automatic send_point(point_row_t r);
    tex_t t;
    if (!calm && $urandom_range(0, 3) == 0) begin
      pt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    pt_if.valid <= 1'b1;
    pt_if.pos_x <= r.x; pt_if.pos_y <= r.y; pt_if.pos_z <= r.z;
    @(posedge clk_i);
    while (!pt_if.ready) @(posedge clk_i);
    t = torus_uv(r.x, r.y, r.z);
    if (r.u != TexNone) t.u = r.u;
    if (r.v != TexNone) t.v = r.v;
    tex_expected.push_back(t);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    pt_if.valid <= 1'b0;
    while (tex_expected.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  function automatic logic signed [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return CoordW'($urandom_range(0, 1023)) - CoordW'(512);
      1: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      2: return CoordW'($urandom_range(0, 327679)) - CoordW'(163840);
      default: return CoordW'($urandom());
    endcase
  endfunction

  // sink side: random stalls, check in order
  initial begin
    tex_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (tex_if.valid && tex_if.ready) begin
        if (tex_expected.size() == 0) begin
          report("unexpected tex_u", tex_if.tex_u, TexNone);
        end else begin
          tex_t e;
          e = tex_expected.pop_front();
          if (tex_if.tex_u !== e.u) report("tex_u", tex_if.tex_u, e.u);
          if (tex_if.tex_v !== e.v) report("tex_v", tex_if.tex_v, e.v);
        end
      end
      if (!calm && tex_if.ready && $urandom_range(0, 5) == 0) begin
        tex_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        tex_if.ready <= 1'b1;
      end else begin
        tex_if.ready <= 1'b1;
      end
    end
  end

  point_row_t directed[] = '{
    '{24'sd0, 24'sd0, 24'sd0, TexHalf, TexFull},
    '{-24'sd65536, 24'sd0, 24'sd0, TexFull, TexHalf},
    '{24'sd65536, 24'sd0, 24'sd0, TexHalf, TexHalf},
    '{24'sd0, 24'sd65536, 24'sd0, 17'd49152, TexHalf},
    '{24'sd0, -24'sd65536, 24'sd0, 17'd16384, TexHalf},
    '{24'sd131072, 24'sd0, 24'sd0, TexHalf, TexHalf},
    '{24'sd131072, 24'sd0, 24'sd65536, TexHalf, 17'd40960},
    '{24'sd131072, 24'sd0, -24'sd65536, TexHalf, 17'd24576},
    '{24'sh7fffff, 24'sh7fffff, 24'sh7fffff, TexNone, TexNone},
    '{24'sh800000, 24'sh800000, 24'sh800000, TexNone, TexNone},
    '{24'sh800000, 24'sh7fffff, 24'sd1, TexNone, TexNone},
    '{24'sh7fffff, 24'sh800000, -24'sd1, TexNone, TexNone},
    '{24'sd1, 24'sd1, 24'sd1, TexNone, TexNone},
    '{-24'sd1, -24'sd1, -24'sd1, TexNone, TexNone},
    '{24'sd46341, 24'sd46341, 24'sd0, TexNone, TexNone},
    '{24'sh555555, 24'shaaaaaa, 24'sh555555, TexNone, TexNone},
    '{24'shaaaaaa, 24'sh555555, 24'shaaaaaa, TexNone, TexNone}
  };

  logic [RingW-1:0] ring_plan[NumPhase] = '{23'd0, 23'h7fffff, 23'd65536, 23'd1, 23'd300000};

  initial begin
    pt_if.valid = 1'b0;
    pt_if.pos_x = '0; pt_if.pos_y = '0; pt_if.pos_z = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_point(directed[i]);
    drain();
    for (int p = 0; p < NumPhase; p++) begin
      reg_write(RegRingRadius, 32'(ring_plan[p]));
      if (p == NumPhase - 1) calm = 1'b1;
      for (int k = 0; k < NumRand / NumPhase; k++) begin
        point_row_t r;
        r.x = rand_coord();
        r.y = rand_coord();
        r.z = rand_coord();
        // points near the tube circle exercise the v sign flips
        if (p != 1 && $urandom_range(0, 3) == 0) begin
          r.x = CoordW'(ring_plan[p]) + CoordW'($urandom_range(0, 63)) - CoordW'(32);
          r.y = '0;
        end
        r.u = TexNone;
        r.v = TexNone;
        send_point(r);
      end
      drain();
    end
    if (tex_expected.size() != 0) begin
      report("missing results", 17'(tex_expected.size()), 17'd0);
    end
    if (mismatch_count == 0) begin
      $display("torus_uv_texture_map_unit_test passed");
    end else begin
      $display("torus_uv_texture_map_unit_test failed");
    end
    $finish;
  end
endmodule
